FILE: src/fep_pkg.sv
// fep_pkg: shared types, constants and palette table of the fire effect pixel engine
package fep_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 192;
    localparam int PIXEL_SCALE_DEF = 4;
    localparam int HEAT_LEVELS_DEF = 37;

    localparam int HEAT_W      = 6;
    localparam int IDX_W       = 10;
    localparam int COLOR_W     = 8;
    localparam int PAL_ENTRIES = 37;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_SHIFT   = 16;

    typedef enum logic {
        REQ_PROPAGATE = 1'b0,
        REQ_RENDER    = 1'b1
    } fep_req_t;

    // one classified item as it travels from the front part to the back part
    typedef struct packed {
        fep_req_t             kind;
        logic                 hit;
        logic                 decay;
        logic [IDX_W-1:0]     rd_row;
        logic [IDX_W-1:0]     rd_col;
        logic [IDX_W-1:0]     wr_row;
        logic [IDX_W-1:0]     wr_col;
        logic [COLOR_W-1:0]   logo_red;
        logic [COLOR_W-1:0]   logo_green;
        logic [COLOR_W-1:0]   logo_blue;
    } fep_item_t;

    // fire palette, red in the top byte
    function automatic logic [3*COLOR_W-1:0] fep_palette(input logic [HEAT_W-1:0] idx);
        logic [3*COLOR_W-1:0] rgb;
        case (idx)
            6'd0:    rgb = 24'h070707;
            6'd1:    rgb = 24'h1F0707;
            6'd2:    rgb = 24'h2F0F07;
            6'd3:    rgb = 24'h470F07;
            6'd4:    rgb = 24'h571707;
            6'd5:    rgb = 24'h671F07;
            6'd6:    rgb = 24'h771F07;
            6'd7:    rgb = 24'h8F2707;
            6'd8:    rgb = 24'h9F2F07;
            6'd9:    rgb = 24'hAF3F07;
            6'd10:   rgb = 24'hBF4707;
            6'd11:   rgb = 24'hC74707;
            6'd12:   rgb = 24'hDF4F07;
            6'd13:   rgb = 24'hDF5707;
            6'd14:   rgb = 24'hDF5707;
            6'd15:   rgb = 24'hD75F07;
            6'd16:   rgb = 24'hD75F07;
            6'd17:   rgb = 24'hD7670F;
            6'd18:   rgb = 24'hCF6F0F;
            6'd19:   rgb = 24'hCF770F;
            6'd20:   rgb = 24'hCF7F0F;
            6'd21:   rgb = 24'hCF8717;
            6'd22:   rgb = 24'hC78717;
            6'd23:   rgb = 24'hC78F17;
            6'd24:   rgb = 24'hC7971F;
            6'd25:   rgb = 24'hBF9F1F;
            6'd26:   rgb = 24'hBF9F1F;
            6'd27:   rgb = 24'hBFA727;
            6'd28:   rgb = 24'hBFA727;
            6'd29:   rgb = 24'hBFAF2F;
            6'd30:   rgb = 24'hB7AF2F;
            6'd31:   rgb = 24'hB7B72F;
            6'd32:   rgb = 24'hB7B737;
            6'd33:   rgb = 24'hCFCF6F;
            6'd34:   rgb = 24'hDFDF9F;
            6'd35:   rgb = 24'hEFEFC7;
            6'd36:   rgb = 24'hFFFFFF;
            default: rgb = 24'hFFFFFF;
        endcase
        return rgb;
    endfunction

endpackage

FILE: src/fire_effect_pixel_engine_top.sv
// fire_effect_pixel_engine_top: top level of the fire effect pixel engine
//
// one input channel (in_valid/in_ready) carries two kinds of item: a propagate
// item cools the heat of one grid cell and writes it one row up, shifted by the
// spread, and gives no result; a render item looks up the heat under a screen
// pixel and gives one colour item on the output channel (out_valid/out_ready)
// throughput: one item per clock while the output is not stalled; the heat
// memory has one write port, used by each propagate item that hits the grid,
// and one registered read port, used once per item; a render result passes
// the input register, the queue and the memory read, then the output register
// a propagate write is forwarded to the very next read of the same cell
// reset: the heat grid is swept once, one cell per clock, over all
// GRID_WIDTH*GRID_HEIGHT cells; in_ready stays low for that sweep
// receiver stall: the output register holds the colour; propagate items keep
// flowing past a stalled render result until the next render item reaches it,
// then the queue fills and in_ready drops
module fire_effect_pixel_engine_top
    import fep_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int PIXEL_SCALE = PIXEL_SCALE_DEF,
    parameter int HEAT_LEVELS = HEAT_LEVELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [7:0]          cell_row,
    input  logic [7:0]          cell_column,
    input  logic                decay,
    input  logic signed [1:0]   spread,
    input  logic [IDX_W-1:0]    pixel_row,
    input  logic [IDX_W-1:0]    pixel_column,
    input  logic [COLOR_W-1:0]  logo_red,
    input  logic [COLOR_W-1:0]  logo_green,
    input  logic [COLOR_W-1:0]  logo_blue,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COLOR_W-1:0]  out_red,
    output logic [COLOR_W-1:0]  out_green,
    output logic [COLOR_W-1:0]  out_blue
);

    // front to queue
    logic       push_valid;
    logic       push_ready;
    fep_item_t  push_item;
    // queue to back
    logic       pop_valid;
    logic       pop_ready;
    fep_item_t  pop_item;
    // high while the heat memory is being swept after reset
    logic       busy;

    fep_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .PIXEL_SCALE (PIXEL_SCALE)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .cell_row     (cell_row),
        .cell_column  (cell_column),
        .decay        (decay),
        .spread       (spread),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .logo_red     (logo_red),
        .logo_green   (logo_green),
        .logo_blue    (logo_blue),
        .busy         (busy),
        .push_valid   (push_valid),
        .push_item    (push_item),
        .push_ready   (push_ready)
    );

    // decouples classification from the memory pipeline
    fep_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    fep_back #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .HEAT_LEVELS (HEAT_LEVELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .busy      (busy),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue)
    );

endmodule

FILE: src/fep_front.sv
// fep_front: input register stage that classifies items and works out grid coordinates
module fep_front
    import fep_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int PIXEL_SCALE = PIXEL_SCALE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                req_type,
    input  logic [7:0]          cell_row,
    input  logic [7:0]          cell_column,
    input  logic                decay,
    input  logic signed [1:0]   spread,
    input  logic [IDX_W-1:0]    pixel_row,
    input  logic [IDX_W-1:0]    pixel_column,
    input  logic [COLOR_W-1:0]  logo_red,
    input  logic [COLOR_W-1:0]  logo_green,
    input  logic [COLOR_W-1:0]  logo_blue,
    input  logic                busy,
    output logic                push_valid,
    output fep_item_t           push_item,
    input  logic                push_ready
);

    localparam int RECIP = (2**DIV_SHIFT + PIXEL_SCALE - 1) / PIXEL_SCALE;
    localparam int PROD_W = IDX_W + DIV_SHIFT + 1;

    logic        f_valid_reg;
    logic        f_valid_next;
    fep_item_t   f_item_reg;
    fep_item_t   f_item_next;
    logic        accept;

    logic [PROD_W-1:0]  prow_prod;
    logic [PROD_W-1:0]  pcol_prod;
    logic [IDX_W-1:0]   prow;
    logic [IDX_W-1:0]   pcol;
    logic signed [11:0] dst_sum;
    logic signed [11:0] dst_wrap;
    logic [IDX_W:0]     src_row;

    assign in_ready = !busy && (!f_valid_reg || push_ready);
    assign accept   = in_valid && in_ready;

    // divide by the pixel scale through a reciprocal multiply
    assign prow_prod = PROD_W'(pixel_row) * PROD_W'(RECIP);
    assign pcol_prod = PROD_W'(pixel_column) * PROD_W'(RECIP);
    assign prow      = prow_prod[DIV_SHIFT +: IDX_W];
    assign pcol      = pcol_prod[DIV_SHIFT +: IDX_W];

    assign src_row = (IDX_W+1)'(cell_row) + (IDX_W+1)'(1);

    // destination column, wrapped across the grid width
    always_comb
    begin
        dst_sum = $signed({4'b0000, cell_column}) + 12'(spread);
        if (dst_sum < 12'sd0)
        begin
            dst_wrap = dst_sum + $signed(12'(GRID_WIDTH));
        end
        else if (dst_sum >= $signed(12'(GRID_WIDTH)))
        begin
            dst_wrap = dst_sum - $signed(12'(GRID_WIDTH));
        end
        else
        begin
            dst_wrap = dst_sum;
        end
    end

    always_comb
    begin
        f_item_next            = f_item_reg;
        f_item_next.decay      = decay;
        f_item_next.logo_red   = logo_red;
        f_item_next.logo_green = logo_green;
        f_item_next.logo_blue  = logo_blue;
        if (req_type == REQ_RENDER)
        begin
            f_item_next.kind   = REQ_RENDER;
            f_item_next.hit    = ((IDX_W+1)'(prow) < (IDX_W+1)'(GRID_HEIGHT))
                              && ((IDX_W+1)'(pcol) < (IDX_W+1)'(GRID_WIDTH));
            f_item_next.rd_row = prow;
            f_item_next.rd_col = pcol;
            f_item_next.wr_row = prow;
            f_item_next.wr_col = pcol;
        end
        else
        begin
            f_item_next.kind   = REQ_PROPAGATE;
            f_item_next.hit    = (src_row < (IDX_W+1)'(GRID_HEIGHT))
                              && ((IDX_W+1)'(cell_column) < (IDX_W+1)'(GRID_WIDTH));
            f_item_next.rd_row = src_row[IDX_W-1:0];
            f_item_next.rd_col = IDX_W'(cell_column);
            f_item_next.wr_row = IDX_W'(cell_row);
            f_item_next.wr_col = dst_wrap[IDX_W-1:0];
        end
    end

    always_comb
    begin
        if (accept)
        begin
            f_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            f_valid_next = 1'b0;
        end
        else
        begin
            f_valid_next = f_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_item_reg <= f_item_next;
        end
    end

    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;

endmodule

FILE: src/fep_queue.sv
// fep_queue: short item queue between the front and back parts
module fep_queue
    import fep_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  fep_item_t  push_item,
    output logic       pop_valid,
    input  logic       pop_ready,
    output fep_item_t  pop_item
);

    fep_item_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QPTR_W:0]    count_reg;
    logic [QPTR_W:0]    count_next;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (QPTR_W+1)'(1);
            2'b01:   count_next = count_reg - (QPTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: src/fep_back.sv
// fep_back: heat memory, clearing pass, propagate and render pipeline, output register
module fep_back
    import fep_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF,
    parameter int HEAT_LEVELS = HEAT_LEVELS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    output logic                busy,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  fep_item_t           pop_item,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [COLOR_W-1:0]  out_red,
    output logic [COLOR_W-1:0]  out_green,
    output logic [COLOR_W-1:0]  out_blue
);

    localparam int DEPTH       = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int BOTTOM_BASE = (GRID_HEIGHT - 1) * GRID_WIDTH;
    localparam int LIMIT       = (HEAT_LEVELS - 1 > PAL_ENTRIES - 1) ? PAL_ENTRIES - 1
                                                                      : HEAT_LEVELS - 1;
    localparam int FULL_HEAT   = (HEAT_LEVELS - 1) % (2**HEAT_W);
    localparam int LIN_W       = 2 * IDX_W + 1;

    logic [HEAT_W-1:0] heat_mem [DEPTH];

    logic               clr_busy_reg;
    logic               clr_busy_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_next;

    logic               b_valid_reg;
    logic               b_valid_next;
    fep_item_t          b_item_reg;
    logic [ADDR_W-1:0]  b_wr_addr_reg;
    logic [HEAT_W-1:0]  rd_data_reg;
    logic               fwd_hit_reg;
    logic               fwd_hit_next;
    logic [HEAT_W-1:0]  fwd_data_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COLOR_W-1:0] out_red_reg;
    logic [COLOR_W-1:0] out_green_reg;
    logic [COLOR_W-1:0] out_blue_reg;

    logic [LIN_W-1:0]   a_rd_lin;
    logic [LIN_W-1:0]   a_wr_lin;
    logic [ADDR_W-1:0]  a_rd_addr;
    logic [ADDR_W-1:0]  a_wr_addr;
    logic               load_b;
    logic               b_fire;
    logic               b_write;
    logic               b_render;

    logic [HEAT_W-1:0]  heat_b;
    logic [HEAT_W-1:0]  prop_heat;
    logic [HEAT_W-1:0]  rnd_heat;
    logic [HEAT_W-1:0]  pal_idx;
    logic [3*COLOR_W-1:0] pal_rgb;
    logic               logo_on;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [HEAT_W-1:0]  mem_wdata;

    assign busy = clr_busy_reg;

    // clearing pass: zero everywhere, full heat along the bottom row
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    // address stage on the queue head
    assign a_rd_lin  = LIN_W'(pop_item.rd_row) * LIN_W'(GRID_WIDTH) + LIN_W'(pop_item.rd_col);
    assign a_wr_lin  = LIN_W'(pop_item.wr_row) * LIN_W'(GRID_WIDTH) + LIN_W'(pop_item.wr_col);
    assign a_rd_addr = pop_item.hit ? a_rd_lin[ADDR_W-1:0] : '0;
    assign a_wr_addr = pop_item.hit ? a_wr_lin[ADDR_W-1:0] : '0;

    assign b_render  = (b_item_reg.kind == REQ_RENDER);
    assign b_fire    = b_valid_reg && (!b_render || !out_valid_reg || out_ready);
    assign pop_ready = !b_valid_reg || b_fire;
    assign load_b    = pop_valid && pop_ready;
    assign b_write   = b_fire && !b_render && b_item_reg.hit;

    // read-during-write returns old data, so the write in flight is forwarded
    assign heat_b    = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign prop_heat = (heat_b > HEAT_W'(b_item_reg.decay))
                     ? heat_b - HEAT_W'(b_item_reg.decay) : '0;
    assign rnd_heat  = b_item_reg.hit ? heat_b : '0;
    assign pal_idx   = (rnd_heat > HEAT_W'(LIMIT)) ? HEAT_W'(LIMIT) : rnd_heat;
    assign pal_rgb   = fep_palette(pal_idx);
    assign logo_on   = (rnd_heat == '0)
                    && ((b_item_reg.logo_red | b_item_reg.logo_green | b_item_reg.logo_blue)
                        != '0);
    assign fwd_hit_next = b_write && (b_wr_addr_reg == a_rd_addr);

    always_comb
    begin
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = (clr_addr_reg >= ADDR_W'(BOTTOM_BASE)) ? HEAT_W'(FULL_HEAT) : '0;
        end
        else
        begin
            mem_we    = b_write;
            mem_waddr = b_wr_addr_reg;
            mem_wdata = prop_heat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heat_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            rd_data_reg <= heat_mem[a_rd_addr];
        end
    end

    always_comb
    begin
        if (load_b)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_fire)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end

        if (b_fire && b_render)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            out_valid_reg <= out_valid_next;
            if (load_b)
            begin
                fwd_hit_reg <= fwd_hit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            b_item_reg    <= pop_item;
            b_wr_addr_reg <= a_wr_addr;
            fwd_data_reg  <= prop_heat;
        end
        if (b_fire && b_render)
        begin
            if (logo_on)
            begin
                out_red_reg   <= b_item_reg.logo_red;
                out_green_reg <= b_item_reg.logo_green;
                out_blue_reg  <= b_item_reg.logo_blue;
            end
            else
            begin
                out_red_reg   <= pal_rgb[3*COLOR_W-1:2*COLOR_W];
                out_green_reg <= pal_rgb[2*COLOR_W-1:COLOR_W];
                out_blue_reg  <= pal_rgb[COLOR_W-1:0];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

endmodule

FILE: src/fep_checker.sv
// fep_checker: port level assertions for the fire effect pixel engine, bound to the top
module fep_checker
    import fep_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                req_type,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [COLOR_W-1:0]  out_red,
    input  logic [COLOR_W-1:0]  out_green,
    input  logic [COLOR_W-1:0]  out_blue
);

    logic render_seen_reg;

    // set once a render item has been taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            render_seen_reg <= 1'b0;
        end
        else if (in_valid && in_ready && (req_type == REQ_RENDER))
        begin
            render_seen_reg <= 1'b1;
        end
    end

    // a stalled result keeps its colour
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_red)
                                    && $stable(out_green) && $stable(out_blue))
        else $error("stalled output item changed");

    // neither palette nor logo path can give black
    a_not_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_red | out_green | out_blue) != '0))
        else $error("output item is black");

    // no result without a render item
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> render_seen_reg)
        else $error("output item without any render item taken");

    // a result can not appear the cycle after the first render item is taken
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        !render_seen_reg |=> !out_valid)
        else $error("output item appeared too early");

endmodule

bind fire_effect_pixel_engine_top fep_checker u_fep_checker (.*);

FILE: dv/tb_fire_effect_pixel_engine_top.sv
// tb_fire_effect_pixel_engine_top: self-checking testbench of the fire effect pixel engine
module tb_fire_effect_pixel_engine_top;

    timeunit 1ns;
    timeprecision 1ps;

    import fep_pkg::*;

    // one input item as the stimulus sees it; typed rows carry their own color
    typedef struct {
        fep_req_t             kind;
        logic [7:0]           row;
        logic [7:0]           col;
        logic                 dec;
        logic [1:0]           spr;
        logic [IDX_W-1:0]     prow;
        logic [IDX_W-1:0]     pcol;
        logic [COLOR_W-1:0]   lr;
        logic [COLOR_W-1:0]   lg;
        logic [COLOR_W-1:0]   lb;
        bit                   typed;
        logic [3*COLOR_W-1:0] rgb;
    } fire_item_t;

    localparam int HOT = HEAT_LEVELS_DEF - 1;

    // flame colors by heat, red in the top byte
    localparam logic [23:0] FLAME_PALETTE [PAL_ENTRIES] = '{
        24'h070707, 24'h1F0707, 24'h2F0F07, 24'h470F07, 24'h571707, 24'h671F07,
        24'h771F07, 24'h8F2707, 24'h9F2F07, 24'hAF3F07, 24'hBF4707, 24'hC74707,
        24'hDF4F07, 24'hDF5707, 24'hDF5707, 24'hD75F07, 24'hD75F07, 24'hD7670F,
        24'hCF6F0F, 24'hCF770F, 24'hCF7F0F, 24'hCF8717, 24'hC78717, 24'hC78F17,
        24'hC7971F, 24'hBF9F1F, 24'hBF9F1F, 24'hBFA727, 24'hBFA727, 24'hBFAF2F,
        24'hB7AF2F, 24'hB7B72F, 24'hB7B737, 24'hCFCF6F, 24'hDFDF9F, 24'hEFEFC7,
        24'hFFFFFF
    };

    // dut connections, the inputs all known from time zero
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               req_type = 1'b0;
    logic [7:0]         cell_row = '0;
    logic [7:0]         cell_column = '0;
    logic               decay = 1'b0;
    logic signed [1:0]  spread = '0;
    logic [IDX_W-1:0]   pixel_row = '0;
    logic [IDX_W-1:0]   pixel_column = '0;
    logic [COLOR_W-1:0] logo_red = '0;
    logic [COLOR_W-1:0] logo_green = '0;
    logic [COLOR_W-1:0] logo_blue = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COLOR_W-1:0] out_red;
    logic [COLOR_W-1:0] out_green;
    logic [COLOR_W-1:0] out_blue;

    // predictor state: private copy of the heat grid
    logic [HEAT_W-1:0]    heat_map [GRID_HEIGHT_DEF][GRID_WIDTH_DEF];
    // colors still owed by the block, oldest first
    logic [3*COLOR_W-1:0] pixel_color_q [$];

    int err_cnt = 0;
    // idle odds in percent for the feeding and the draining side
    int feed_idle_pct = 0;
    int drain_idle_pct = 0;

    fire_effect_pixel_engine_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .cell_row     (cell_row),
        .cell_column  (cell_column),
        .decay        (decay),
        .spread       (spread),
        .pixel_row    (pixel_row),
        .pixel_column (pixel_column),
        .logo_red     (logo_red),
        .logo_green   (logo_green),
        .logo_blue    (logo_blue),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue)
    );

    always #10 clk = ~clk;

    // hard stop: the time limit lies well beyond what the reset sweep and
    // a correct run with all stalls need
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic fire_item_t mk_prop(int row, int col, bit dec, int spr);
        fire_item_t it;
        it = '{kind: REQ_PROPAGATE, row: 8'(row), col: 8'(col), dec: dec, spr: 2'(spr),
               prow: '0, pcol: '0, lr: '0, lg: '0, lb: '0, typed: 1'b0, rgb: '0};
        return it;
    endfunction

    // rgb is only used when typed is set
    function automatic fire_item_t mk_rend(int prow, int pcol, logic [23:0] logo,
                                           bit typed, logic [23:0] rgb);
        fire_item_t it;
        it = '{kind: REQ_RENDER, row: '0, col: '0, dec: 1'b0, spr: '0,
               prow: IDX_W'(prow), pcol: IDX_W'(pcol),
               lr: logo[23:16], lg: logo[15:8], lb: logo[7:0],
               typed: typed, rgb: rgb};
        return it;
    endfunction

    // advance the private grid by one accepted item, queue the color it owes
    function automatic void apply_fire_item(fire_item_t it);
        int shift;
        int dst;
        int gr;
        int gc;
        int heat;
        if (it.kind == REQ_PROPAGATE)
        begin
            // source row beyond the grid: nothing happens
            if (int'(it.row) + 1 < GRID_HEIGHT_DEF && int'(it.col) < GRID_WIDTH_DEF)
            begin
                shift = $signed(it.spr);    // pattern 2'b10 moves two to the left
                dst   = (int'(it.col) + shift + GRID_WIDTH_DEF) % GRID_WIDTH_DEF;
                heat  = int'(heat_map[int'(it.row) + 1][it.col]);
                heat  = (heat > int'(it.dec)) ? heat - int'(it.dec) : 0;
                heat_map[it.row][dst] = heat[HEAT_W-1:0];
            end
        end
        else
        begin
            gr   = int'(it.prow) / PIXEL_SCALE_DEF;
            gc   = int'(it.pcol) / PIXEL_SCALE_DEF;
            // off-grid pixels read as cold
            heat = (gr < GRID_HEIGHT_DEF && gc < GRID_WIDTH_DEF) ? int'(heat_map[gr][gc]) : 0;
            if (heat > HOT)
                heat = HOT;
            if (it.typed)
                pixel_color_q.push_back(it.rgb);
            else if (heat == 0 && {it.lr, it.lg, it.lb} != '0)
                pixel_color_q.push_back({it.lr, it.lg, it.lb});
            else
                pixel_color_q.push_back(FLAME_PALETTE[heat]);
        end
    endfunction

    // present one item, hold it until taken, then predict
    task automatic send_item(fire_item_t it);
        if ($urandom_range(99) < feed_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < feed_idle_pct);
        end
        req_type     <= it.kind;
        cell_row     <= it.row;
        cell_column  <= it.col;
        decay        <= it.dec;
        spread       <= it.spr;
        pixel_row    <= it.prow;
        pixel_column <= it.pcol;
        logo_red     <= it.lr;
        logo_green   <= it.lg;
        logo_blue    <= it.lb;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        apply_fire_item(it);
    endtask

    function automatic void check_channel(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t: %s expected %02h actual %02h", $time, name, want, got);
        end
    endfunction

    // output side: check every taken color, then pick the next ready level
    always @(posedge clk)
    begin
        logic [23:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pixel_color_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: color expected none actual %02h%02h%02h",
                         $time, out_red, out_green, out_blue);
            end
            else
            begin
                want = pixel_color_q.pop_front();
                check_channel("out_red", want[23:16], out_red);
                check_channel("out_green", want[15:8], out_green);
                check_channel("out_blue", want[7:0], out_blue);
            end
        end
        out_ready <= ($urandom_range(99) >= drain_idle_pct);
    end

    initial
    begin
        fire_item_t plan [$];
        fire_item_t it;
        int n_live;
        int last_row;
        int last_dst;
        int shift;

        // grid after reset: cold, bottom row fully hot
        foreach (heat_map[r, c])
            heat_map[r][c] = (r == GRID_HEIGHT_DEF - 1) ? HEAT_W'(HOT) : '0;

        // directed table
        // cold corner, no logo: darkest palette entry
        plan.push_back(mk_rend(0, 0, 24'h000000, 1'b1, 24'h070707));
        // hot bottom row at the far corner: white
        plan.push_back(mk_rend(767, 1023, 24'h000000, 1'b1, 24'hFFFFFF));
        // logo hidden behind hot fire
        plan.push_back(mk_rend(764, 0, 24'h123456, 1'b1, 24'hFFFFFF));
        // logo shows through cold fire
        plan.push_back(mk_rend(0, 1023, 24'hFFFFFF, 1'b1, 24'hFFFFFF));
        // off-grid pixel with and without a logo, then a faint logo on a cold cell
        plan.push_back(mk_rend(1023, 1023, 24'h000000, 1'b1, 24'h070707));
        plan.push_back(mk_rend(768, 512, 24'h010080, 1'b1, 24'h010080));
        plan.push_back(mk_rend(3, 3, 24'h000001, 1'b1, 24'h000001));
        // cooling, then spread right with wrap, left, and the minus-two pattern
        plan.push_back(mk_prop(190, 0, 1'b1, 0));
        plan.push_back(mk_rend(760, 0, 24'h000000, 1'b0, '0));
        plan.push_back(mk_prop(190, 255, 1'b0, 1));
        plan.push_back(mk_rend(763, 3, 24'hFF00FF, 1'b0, '0));
        plan.push_back(mk_prop(190, 0, 1'b1, 3));
        plan.push_back(mk_prop(190, 1, 1'b1, 2));
        plan.push_back(mk_rend(762, 1020, 24'hAA55AA, 1'b0, '0));
        // back-to-back chain reading cells just written
        plan.push_back(mk_prop(189, 255, 1'b1, 0));
        plan.push_back(mk_prop(188, 255, 1'b1, 1));
        plan.push_back(mk_rend(752, 0, 24'h00FF00, 1'b0, '0));
        // source row at or past the bottom: ignored
        plan.push_back(mk_prop(191, 10, 1'b0, 0));
        plan.push_back(mk_prop(255, 10, 1'b1, 1));
        // cold source floors at zero
        plan.push_back(mk_prop(0, 128, 1'b1, 3));
        plan.push_back(mk_rend(0, 508, 24'hFF0000, 1'b0, '0));
        // write immediately followed by a render of the same cell
        plan.push_back(mk_prop(190, 2, 1'b1, 0));
        plan.push_back(mk_rend(761, 9, 24'h000000, 1'b0, '0));

        // reset, then in_ready stays low through the grid sweep
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        feed_idle_pct  = 26;
        drain_idle_pct = 64;
        foreach (plan[i])
            send_item(plan[i]);

        // random part: fire chains climbing from the bottom row, renders near
        // the hot region or on the last written cell, some noise everywhere
        n_live   = 0;
        last_row = GRID_HEIGHT_DEF - 2;
        last_dst = 0;
        while (n_live < 650)
        begin
            if (n_live >= 434)
            begin
                feed_idle_pct  = 0;
                drain_idle_pct = 0;
            end
            else if (n_live >= 217)
            begin
                feed_idle_pct  = 64;
                drain_idle_pct = 26;
            end

            // unused fields get random values too
            it.row   = 8'($urandom_range(255));
            it.col   = 8'($urandom_range(255));
            it.dec   = 1'($urandom_range(1));
            it.spr   = 2'($urandom_range(3));
            it.prow  = IDX_W'($urandom_range(1023));
            it.pcol  = IDX_W'($urandom_range(1023));
            it.lr    = COLOR_W'($urandom_range(255));
            it.lg    = COLOR_W'($urandom_range(255));
            it.lb    = COLOR_W'($urandom_range(255));
            it.typed = 1'b0;
            it.rgb   = '0;

            if ($urandom_range(99) < 55)
            begin
                it.kind = REQ_PROPAGATE;
                case ($urandom_range(9))
                    0: ;    // anywhere, some past the bottom
                    1, 2, 3, 4:
                    begin
                        // climb one row from the cell just written
                        it.row = 8'((last_row > 0) ? last_row - 1 : GRID_HEIGHT_DEF - 2);
                        it.col = 8'((last_row > 0) ? last_dst : int'($urandom_range(255)));
                    end
                    default: it.row = 8'($urandom_range(GRID_HEIGHT_DEF - 2, 160));
                endcase
                if (int'(it.row) + 1 < GRID_HEIGHT_DEF)
                begin
                    shift    = $signed(it.spr);
                    last_row = int'(it.row);
                    last_dst = (int'(it.col) + shift + GRID_WIDTH_DEF) % GRID_WIDTH_DEF;
                end
            end
            else
            begin
                it.kind = REQ_RENDER;
                case ($urandom_range(9))
                    0, 1: ;    // anywhere, including off-grid
                    2, 3, 4:
                    begin
                        it.prow = IDX_W'(last_row * PIXEL_SCALE_DEF + int'($urandom_range(3)));
                        it.pcol = IDX_W'(last_dst * PIXEL_SCALE_DEF + int'($urandom_range(3)));
                    end
                    default: it.prow = IDX_W'($urandom_range(767, 600));
                endcase
                // half without logo, some with a single channel lit
                case ($urandom_range(3))
                    0, 1: {it.lr, it.lg, it.lb} = '0;
                    2:
                    begin
                        if ($urandom_range(1))
                            {it.lr, it.lb} = '0;
                        else
                            {it.lg, it.lb} = '0;
                    end
                    default: ;
                endcase
            end

            send_item(it);
            // ignored propagates do not count
            if (!(it.kind == REQ_PROPAGATE && int'(it.row) + 1 >= GRID_HEIGHT_DEF))
                n_live++;
        end
        in_valid <= 1'b0;

        // drain, then keep watching the output for anything unexpected
        while (pixel_color_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: fire_effect_pixel_engine_top.f
src/fep_pkg.sv
src/fep_front.sv
src/fep_queue.sv
src/fep_back.sv
src/fire_effect_pixel_engine_top.sv
src/fep_checker.sv
dv/tb_fire_effect_pixel_engine_top.sv
